// ===== rtl/dds_tuning_word_serial_loader_core_macros.svh =====
// Assertion macros used by the checker file of the tuning word loader.
`ifndef DDS_TUNING_WORD_SERIAL_LOADER_CORE_MACROS_SVH
`define DDS_TUNING_WORD_SERIAL_LOADER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DTWL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DTWL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dtwl_pkg.sv =====
// Types and constants shared by the tuning word loader modules.
package dtwl_pkg;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_RESET = 1'b1
  } op_e;

  localparam int unsigned WordW = 32;
  localparam int unsigned FreqW = 27;
  localparam int unsigned ProdW = 54;
  localparam int unsigned CntW  = 6;

  localparam logic [FreqW-1:0] SYS_CLOCK_HZ = 27'd125000000;

  // The reciprocal is ceil(2^74 / 5^9); for a frequency below the system clock the product
  // shifted down by 48 bits is exactly floor(frequency * 2^32 / 125 MHz).
  localparam logic [ProdW-1:0] FTW_RECIP    = 54'd9671406556917034;
  localparam logic [FreqW-1:0] FTW_RECIP_HI = FTW_RECIP[ProdW-1:FreqW];
  localparam logic [FreqW-1:0] FTW_RECIP_LO = FTW_RECIP[FreqW-1:0];
  localparam int unsigned      SumLsb       = 21;

  localparam logic [CntW-1:0] SERIAL_BITS     = 6'd40;
  localparam logic [CntW-1:0] RST_STEP_PULSE  = 6'd0;
  localparam logic [CntW-1:0] RST_STEP_WCLK   = 6'd1;
  localparam logic [CntW-1:0] RST_STEP_UPDATE = 6'd2;

  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] tword;
  } entry_t;

endpackage

// ===== rtl/dtwl_front.sv =====
// Front end: accepts commands and computes the tuning word by reciprocal multiplication.
module dtwl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [31:0]       frequency_hz_i,
  output logic              ent_valid_o,
  input  logic              ent_ready_i,
  output dtwl_pkg::entry_t  ent_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_HOLD
  } state_e;

  state_e                          state_q, state_d;
  logic [dtwl_pkg::FreqW-1:0]      freq_q, freq_d;
  logic [dtwl_pkg::ProdW-1:0]      prod_hi_q, prod_hi_d;
  logic [dtwl_pkg::ProdW-1:0]      prod_lo_q, prod_lo_d;
  logic [dtwl_pkg::WordW-1:0]      quo_q, quo_d;
  dtwl_pkg::op_e                   op_q, op_d;
  logic [dtwl_pkg::ProdW:0]        sum;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign ent_valid_o = (state_q == ST_HOLD);
  assign ent_o.op    = op_q;
  assign ent_o.tword = quo_q;

  // The high partial product already carries a weight of 2^27.
  assign sum = {1'b0, prod_hi_q} +
               {{(dtwl_pkg::FreqW+1){1'b0}}, prod_lo_q[dtwl_pkg::ProdW-1:dtwl_pkg::FreqW]};

  always_comb begin
    state_d   = state_q;
    freq_d    = freq_q;
    prod_hi_d = prod_hi_q;
    prod_lo_d = prod_lo_q;
    quo_d     = quo_q;
    op_d      = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d = dtwl_pkg::op_e'(opcode_i);
          if (opcode_i == dtwl_pkg::OP_RESET) begin
            quo_d   = '0;
            state_d = ST_HOLD;
          end else if (frequency_hz_i >= {5'd0, dtwl_pkg::SYS_CLOCK_HZ}) begin
            quo_d   = '1;
            state_d = ST_HOLD;
          end else begin
            freq_d  = frequency_hz_i[dtwl_pkg::FreqW-1:0];
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_hi_d = {{dtwl_pkg::FreqW{1'b0}}, freq_q} *
                    {{dtwl_pkg::FreqW{1'b0}}, dtwl_pkg::FTW_RECIP_HI};
        prod_lo_d = {{dtwl_pkg::FreqW{1'b0}}, freq_q} *
                    {{dtwl_pkg::FreqW{1'b0}}, dtwl_pkg::FTW_RECIP_LO};
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        quo_d   = sum[dtwl_pkg::SumLsb+dtwl_pkg::WordW-1:dtwl_pkg::SumLsb];
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (ent_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= dtwl_pkg::OP_LOAD;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q    <= freq_d;
    prod_hi_q <= prod_hi_d;
    prod_lo_q <= prod_lo_d;
    quo_q     <= quo_d;
  end

endmodule

// ===== rtl/dtwl_queue.sv =====
// Two-entry queue between the front end and the serialiser.
module dtwl_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  dtwl_pkg::entry_t  push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output dtwl_pkg::entry_t  pop_data_o
);

  dtwl_pkg::entry_t mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/dtwl_back.sv =====
// Back end: turns queued commands into pin event words through an output register.
module dtwl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ent_valid_i,
  output logic              ent_ready_o,
  input  dtwl_pkg::entry_t  ent_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              data_bit_o,
  output logic              word_clock_pulse_o,
  output logic              update_pulse_o,
  output logic              reset_pulse_o,
  output logic              last_o
);

  logic                        active_q, active_d;
  dtwl_pkg::op_e               op_q, op_d;
  logic [dtwl_pkg::WordW-1:0]  shift_q, shift_d;
  logic [dtwl_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        valid_q, valid_d;
  logic                        data_q, data_d;
  logic                        wclk_q, wclk_d;
  logic                        upd_q, upd_d;
  logic                        rst_q, rst_d;
  logic                        last_q, last_d;
  logic                        adv;
  logic                        fin;
  logic                        pop;

  assign adv = !valid_q || out_ready_i;
  assign fin = active_q &&
               (((op_q == dtwl_pkg::OP_LOAD) && (cnt_q == dtwl_pkg::SERIAL_BITS)) ||
                ((op_q == dtwl_pkg::OP_RESET) && (cnt_q == dtwl_pkg::RST_STEP_UPDATE)));
  assign pop = ent_valid_i && (!active_q || (adv && fin));
  assign ent_ready_o = !active_q || (adv && fin);

  always_comb begin
    active_d = active_q;
    op_d     = op_q;
    shift_d  = shift_q;
    cnt_d    = cnt_q;
    valid_d  = valid_q;
    data_d   = data_q;
    wclk_d   = wclk_q;
    upd_d    = upd_q;
    rst_d    = rst_q;
    last_d   = last_q;
    if (adv) begin
      valid_d = active_q;
      data_d  = 1'b0;
      wclk_d  = 1'b0;
      upd_d   = 1'b0;
      rst_d   = 1'b0;
      last_d  = 1'b0;
      if (active_q) begin
        cnt_d = cnt_q + 6'd1;
        case (op_q)
          dtwl_pkg::OP_LOAD: begin
            if (cnt_q == dtwl_pkg::SERIAL_BITS) begin
              upd_d  = 1'b1;
              last_d = 1'b1;
            end else begin
              data_d  = shift_q[0];
              wclk_d  = 1'b1;
              shift_d = shift_q >> 1;
            end
          end
          dtwl_pkg::OP_RESET: begin
            case (cnt_q)
              dtwl_pkg::RST_STEP_PULSE: rst_d  = 1'b1;
              dtwl_pkg::RST_STEP_WCLK:  wclk_d = 1'b1;
              default: begin
                upd_d  = 1'b1;
                last_d = 1'b1;
              end
            endcase
          end
          default: begin
            upd_d  = 1'b1;
            last_d = 1'b1;
          end
        endcase
        if (fin) begin
          active_d = 1'b0;
        end
      end
    end
    if (pop) begin
      active_d = 1'b1;
      op_d     = ent_i.op;
      shift_d  = ent_i.tword;
      cnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      op_q     <= dtwl_pkg::OP_LOAD;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
      op_q     <= op_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    data_q  <= data_d;
    wclk_q  <= wclk_d;
    upd_q   <= upd_d;
    rst_q   <= rst_d;
    last_q  <= last_d;
  end

  assign out_valid_o        = valid_q;
  assign data_bit_o         = data_q;
  assign word_clock_pulse_o = wclk_q;
  assign update_pulse_o     = upd_q;
  assign reset_pulse_o      = rst_q;
  assign last_o             = last_q;

endmodule

// ===== rtl/dds_tuning_word_serial_loader_core.sv =====
// Top level of the serial tuning word loader for a 40-bit DDS control register.
//
//   Port group   Direction  Handshake              Word
//   in           input      in_valid_i/in_ready_o   opcode_i, frequency_hz_i
//   out          output     out_valid_o/out_ready_i data_bit_o, word_clock_pulse_o,
//                                                  update_pulse_o, reset_pulse_o, last_o
//
// A load command gives 41 output words and a reset command gives 3, one word per cycle
// while out_ready_i is high. A load below the system clock steps the front end through
// taking the word, two 27 by 27 bit partial products, adding them and handing over.
// A reset command or a saturating load goes from taking the word straight to the hand-over.
// The front end overlaps with the serial output of the previous command, and the back end
// starts each command straight after the last word of the one before.
// A two-entry queue lets either side stall without holding up the other until it is full or empty.
// Reset is asynchronous and active low; it empties the queue and clears the output.
module dds_tuning_word_serial_loader_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] frequency_hz_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        data_bit_o,
  output logic        word_clock_pulse_o,
  output logic        update_pulse_o,
  output logic        reset_pulse_o,
  output logic        last_o
);

  logic             fr_valid;
  logic             fr_ready;
  dtwl_pkg::entry_t fr_ent;
  logic             bk_valid;
  logic             bk_ready;
  dtwl_pkg::entry_t bk_ent;

  dtwl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .frequency_hz_i (frequency_hz_i),
    .ent_valid_o    (fr_valid),
    .ent_ready_i    (fr_ready),
    .ent_o          (fr_ent)
  );

  dtwl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_ent),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_ent)
  );

  dtwl_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ent_valid_i        (bk_valid),
    .ent_ready_o        (bk_ready),
    .ent_i              (bk_ent),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .data_bit_o         (data_bit_o),
    .word_clock_pulse_o (word_clock_pulse_o),
    .update_pulse_o     (update_pulse_o),
    .reset_pulse_o      (reset_pulse_o),
    .last_o             (last_o)
  );

endmodule

// ===== rtl/dtwl_checker.sv =====
// Port-level checker for the tuning word loader, bound to the top level.
`include "dds_tuning_word_serial_loader_core_macros.svh"

module dtwl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        opcode_i,
  input logic [31:0] frequency_hz_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        data_bit_o,
  input logic        word_clock_pulse_o,
  input logic        update_pulse_o,
  input logic        reset_pulse_o,
  input logic        last_o
);

  logic [32:0] in_word;
  logic [4:0]  out_word;
  logic [2:0]  out_pins;
  logic        in_wait;
  logic        out_wait;
  logic        no_wclk;

  assign in_word  = {opcode_i, frequency_hz_i};
  assign out_word = {data_bit_o, word_clock_pulse_o, update_pulse_o, reset_pulse_o, last_o};
  assign out_pins = {word_clock_pulse_o, update_pulse_o, reset_pulse_o};
  assign in_wait  = in_valid_i && !in_ready_o;
  assign out_wait = out_valid_o && !out_ready_i;
  assign no_wclk  = out_valid_o && !word_clock_pulse_o;

  `DTWL_ASSERT_NEXT(a_in_hold, in_wait, in_valid_i && $stable(in_word), "input word not held")
  `DTWL_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_word), "output not held")
  `DTWL_ASSERT_NOW(a_one_pin, out_valid_o, $onehot(out_pins), "not exactly one pin event")
  `DTWL_ASSERT_NOW(a_last_upd, out_valid_o, last_o == update_pulse_o, "last off the update")
  `DTWL_ASSERT_NOW(a_data_idle, no_wclk, !data_bit_o, "data high outside a word clock")

endmodule

bind dds_tuning_word_serial_loader_core dtwl_checker u_dtwl_checker (.*);

// ===== sim/dds_tuning_word_serial_loader_core_tb.sv =====
// Self-checking testbench for the serial tuning word loader, with random handshake idling.
`timescale 1ns / 1ps

module dds_tuning_word_serial_loader_core_tb;

  localparam int unsigned RandomItems = 380;
  localparam int unsigned TailItems   = 40;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned CycleLimit  = 2000000;
  localparam logic [63:0] ClockHz     = 64'd125000000;
  localparam logic [7:0]  CtrlByte    = 8'h00;

  typedef struct packed {
    logic data_bit;
    logic word_clock_pulse;
    logic update_pulse;
    logic reset_pulse;
    logic last;
  } pin_event_t;

  typedef struct {
    dtwl_pkg::op_e op;
    logic [31:0]   hz;
  } command_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = 1'b0;
  logic [31:0] frequency_hz_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        data_bit_o;
  logic        word_clock_pulse_o;
  logic        update_pulse_o;
  logic        reset_pulse_o;
  logic        last_o;

  command_t   command_q[$];
  pin_event_t pin_event_q[$];
  int unsigned failures = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit          send_idling = 1'b1;
  bit          recv_idling = 1'b1;

  dds_tuning_word_serial_loader_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .frequency_hz_i     (frequency_hz_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .data_bit_o         (data_bit_o),
    .word_clock_pulse_o (word_clock_pulse_o),
    .update_pulse_o     (update_pulse_o),
    .reset_pulse_o      (reset_pulse_o),
    .last_o             (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] calc_ftw(logic [31:0] hz);
    logic [63:0] quotient;
    quotient = {hz, 32'h0} / ClockHz;
    return (quotient[63:32] != '0) ? 32'hFFFF_FFFF : quotient[31:0];
  endfunction

  function automatic void predict_pin_events(dtwl_pkg::op_e op, logic [31:0] hz);
    logic [39:0] serial;
    if (op == dtwl_pkg::OP_RESET) begin
      pin_event_q.push_back('{1'b0, 1'b0, 1'b0, 1'b1, 1'b0});
      pin_event_q.push_back('{1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
      pin_event_q.push_back('{1'b0, 1'b0, 1'b1, 1'b0, 1'b1});
    end else begin
      serial = {CtrlByte, calc_ftw(hz)};
      for (int i = 0; i < 40; i++) begin
        pin_event_q.push_back('{serial[i], 1'b1, 1'b0, 1'b0, 1'b0});
      end
      pin_event_q.push_back('{1'b0, 1'b0, 1'b1, 1'b0, 1'b1});
    end
  endfunction

  function automatic void add_command(dtwl_pkg::op_e op, logic [31:0] hz);
    command_q.push_back('{op, hz});
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt[7:0] == 8'd0) begin
      send_idling <= ($urandom_range(0, 2) != 0);
      recv_idling <= ($urandom_range(0, 2) != 0);
    end
    if (cycle_cnt >= CycleLimit) begin
      $display("dds_tuning_word_serial_loader_core regression: fail");
      $finish;
    end
  end

  // Driver: presents the oldest pending command, with random gaps between words.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_pin_events(dtwl_pkg::op_e'(opcode_i), frequency_hz_i);
        void'(command_q.pop_front());
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (command_q.size() > TailItems && send_idling &&
                     $urandom_range(0, 3) == 0) begin
          send_gap   <= $urandom_range(0, 18);
          in_valid_i <= 1'b0;
        end else if (command_q.size() != 0) begin
          in_valid_i     <= 1'b1;
          opcode_i       <= command_q[0].op;
          frequency_hz_i <= command_q[0].hz;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted word against the oldest predicted pin event.
  always @(posedge clk_i) begin
    pin_event_t got;
    pin_event_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{data_bit_o, word_clock_pulse_o, update_pulse_o, reset_pulse_o, last_o};
        if (pin_event_q.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("unexpected word: data=%0b wclk=%0b update=%0b reset=%0b last=%0b",
                     got.data_bit, got.word_clock_pulse, got.update_pulse,
                     got.reset_pulse, got.last);
          end
        end else begin
          want = pin_event_q.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10) begin
              $display("mismatch: expected data=%0b wclk=%0b update=%0b reset=%0b last=%0b",
                       want.data_bit, want.word_clock_pulse, want.update_pulse,
                       want.reset_pulse, want.last);
              $display("          actual   data=%0b wclk=%0b update=%0b reset=%0b last=%0b",
                       got.data_bit, got.word_clock_pulse, got.update_pulse,
                       got.reset_pulse, got.last);
            end
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall  <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else if (command_q.size() > TailItems && recv_idling &&
                   $urandom_range(0, 5) == 0) begin
        recv_stall  <= $urandom_range(0, 18);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [31:0] hz;

    add_command(dtwl_pkg::OP_RESET, 32'h0000_0000);
    add_command(dtwl_pkg::OP_RESET, 32'hFFFF_FFFF);
    add_command(dtwl_pkg::OP_LOAD, 32'd0);
    add_command(dtwl_pkg::OP_LOAD, 32'd1);
    add_command(dtwl_pkg::OP_LOAD, 32'd2);
    add_command(dtwl_pkg::OP_LOAD, 32'd62500000);
    add_command(dtwl_pkg::OP_LOAD, 32'd124999999);
    add_command(dtwl_pkg::OP_LOAD, 32'd125000000);
    add_command(dtwl_pkg::OP_LOAD, 32'd125000001);
    add_command(dtwl_pkg::OP_LOAD, 32'hFFFF_FFFF);
    add_command(dtwl_pkg::OP_LOAD, 32'h8000_0000);
    add_command(dtwl_pkg::OP_LOAD, 32'h0555_5555);
    add_command(dtwl_pkg::OP_LOAD, 32'h0AAA_AAAA);
    add_command(dtwl_pkg::OP_RESET, 32'h1234_5678);
    add_command(dtwl_pkg::OP_LOAD, 32'd1000000);
    add_command(dtwl_pkg::OP_RESET, 32'd0);
    add_command(dtwl_pkg::OP_RESET, 32'd0);
    add_command(dtwl_pkg::OP_LOAD, 32'd124999998);

    for (int n = 0; n < RandomItems; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        hz = $urandom_range(0, 124999999);
      end else if (pick < 70) begin
        hz = $urandom;
      end else if (pick < 82) begin
        hz = 32'd125000000 + $urandom_range(0, 64) - 32;
      end else if (pick < 88) begin
        hz = $urandom_range(0, 255);
      end else begin
        hz = $urandom;
        add_command(dtwl_pkg::OP_RESET, hz);
        continue;
      end
      add_command(dtwl_pkg::OP_LOAD, hz);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (command_q.size() != 0 || in_valid_i || pin_event_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (failures == 0 && pin_event_q.size() == 0) begin
      $display("dds_tuning_word_serial_loader_core regression: pass");
    end else begin
      $display("dds_tuning_word_serial_loader_core regression: fail");
    end
    $finish;
  end

endmodule
